// ----- rtl/core/ilt_pkg.sv -----
// Shared constants for the indexed list table: command modes, status codes,
// default depth and field widths. No dependencies.
`default_nettype none
package ilt_pkg;

  localparam int DefDepth = 256;

  localparam int ModeW   = 3;
  localparam int IndexW  = 9;
  localparam int WordW   = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 9;

  localparam logic [ModeW-1:0] ModeAppend = 3'd0;
  localparam logic [ModeW-1:0] ModeInsert = 3'd1;
  localparam logic [ModeW-1:0] ModeDelete = 3'd2;
  localparam logic [ModeW-1:0] ModeSearch = 3'd3;
  localparam logic [ModeW-1:0] ModeRead   = 3'd4;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StRange = 2'd2;

  localparam logic [WordW-1:0] ReadMiss = '1;

endpackage
`default_nettype wire

// ----- rtl/core/ilt_ifs.sv -----
// Request and result channels of the indexed list table (valid/ready).
// Depends on ilt_pkg for field widths.
`default_nettype none
interface ilt_cmd_if;
  logic                             valid;
  logic                             ready;
  logic        [ilt_pkg::ModeW-1:0]  mode;
  logic        [ilt_pkg::IndexW-1:0] index;
  logic signed [ilt_pkg::WordW-1:0]  value;

  modport source (output valid, mode, index, value, input ready);
  modport sink   (input valid, mode, index, value, output ready);
endinterface

interface ilt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic        [ilt_pkg::StatusW-1:0] status;
  logic signed [ilt_pkg::WordW-1:0]   read_value;
  logic                               found;
  logic        [ilt_pkg::CountW-1:0]  count;

  modport source (output valid, status, read_value, found, count, input ready);
  modport sink   (input valid, status, read_value, found, count, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ilt_mem.sv -----
// Entry storage of the indexed list table: one write port, one read port
// with registered read data. Port bundle type comes from the top level.
`default_nettype none
module ilt_mem #(
  parameter int  Depth = ilt_pkg::DefDepth,
  parameter type req_t = logic
) (
  input  wire                             clk,
  input  req_t                            req,
  output logic [ilt_pkg::WordW-1:0]       rd_data
);

  logic [ilt_pkg::WordW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/ilt_seq.sv -----
// Command sequencer of the indexed list table: decodes a request, walks the
// entry memory one address per cycle with a single compare/step unit, and
// holds the result register. Depends on ilt_pkg and ilt_ifs.
`default_nettype none
module ilt_seq #(
  parameter int  Depth = ilt_pkg::DefDepth,
  parameter type req_t = logic
) (
  input  wire                        clk,
  input  wire                        rst,
  ilt_cmd_if.sink                    cmd,
  ilt_rsp_if.source                  rsp,
  output req_t                       mem_req,
  input  wire [ilt_pkg::WordW-1:0]   rd_data
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam int XW = (CW > ilt_pkg::IndexW) ? CW : ilt_pkg::IndexW;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_SHIFT_UP = 8'b0000_0100,
    S_PLACE    = 8'b0000_1000,
    S_SHIFT_DN = 8'b0001_0000,
    S_SCAN     = 8'b0010_0000,
    S_RDWAIT   = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t                        state, state_next;
  logic [ilt_pkg::ModeW-1:0]     op_mode, op_mode_next;
  logic [XW-1:0]                 op_index, op_index_next;
  logic [ilt_pkg::WordW-1:0]     op_value, op_value_next;
  logic [AW-1:0]                 ptr, ptr_next;
  logic [CW-1:0]                 count, count_next;
  logic [ilt_pkg::StatusW-1:0]   st, st_next;
  logic [ilt_pkg::WordW-1:0]     rdv, rdv_next;
  logic                          hit, hit_next;
  logic                          rsp_valid;
  logic                          rsp_load;

  logic [XW-1:0] count_x;
  logic [XW-1:0] last_x;
  logic [AW-1:0] last;
  logic [AW-1:0] idx_a;
  logic          is_full;

  assign count_x = XW'(count);
  assign last_x  = count_x - XW'(1);
  assign last    = last_x[AW-1:0];
  assign idx_a   = op_index[AW-1:0];
  assign is_full = (count_x >= XW'(Depth));

  assign cmd.ready = (state == S_IDLE);
  assign rsp_load  = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  always_comb begin
    state_next    = state;
    op_mode_next  = op_mode;
    op_index_next = op_index;
    op_value_next = op_value;
    ptr_next      = ptr;
    count_next    = count;
    st_next       = st;
    rdv_next      = rdv;
    hit_next      = hit;
    mem_req       = '0;
    mem_req.raddr = ptr;

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          op_mode_next  = cmd.mode;
          op_index_next = XW'(cmd.index);
          op_value_next = cmd.value;
          st_next       = ilt_pkg::StOk;
          rdv_next      = '0;
          hit_next      = 1'b0;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FINISH;
        unique case (op_mode)
          ilt_pkg::ModeAppend: begin
            if (is_full) begin
              st_next = ilt_pkg::StFull;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count_x[AW-1:0];
              mem_req.wdata = op_value;
              count_next    = count + CW'(1);
            end
          end
          ilt_pkg::ModeInsert: begin
            if (op_index > count_x) begin
              st_next = ilt_pkg::StRange;
            end else if (is_full) begin
              st_next = ilt_pkg::StFull;
            end else if (op_index == count_x) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = idx_a;
              mem_req.wdata = op_value;
              count_next    = count + CW'(1);
            end else begin
              mem_req.raddr = last;
              ptr_next      = last;
              state_next    = S_SHIFT_UP;
            end
          end
          ilt_pkg::ModeDelete: begin
            if (op_index >= count_x) begin
              st_next = ilt_pkg::StRange;
            end else if (op_index == last_x) begin
              count_next = count - CW'(1);
            end else begin
              mem_req.raddr = idx_a + AW'(1);
              ptr_next      = idx_a + AW'(1);
              state_next    = S_SHIFT_DN;
            end
          end
          ilt_pkg::ModeSearch: begin
            if (count_x != '0) begin
              mem_req.raddr = '0;
              ptr_next      = '0;
              state_next    = S_SCAN;
            end
          end
          ilt_pkg::ModeRead: begin
            if (op_index >= count_x) begin
              st_next  = ilt_pkg::StRange;
              rdv_next = ilt_pkg::ReadMiss;
            end else begin
              mem_req.raddr = idx_a;
              state_next    = S_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_UP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr + AW'(1);
        mem_req.wdata = rd_data;
        mem_req.raddr = ptr - AW'(1);
        if (ptr == idx_a) begin
          state_next = S_PLACE;
        end else begin
          ptr_next = ptr - AW'(1);
        end
      end
      S_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_a;
        mem_req.wdata = op_value;
        count_next    = count + CW'(1);
        state_next    = S_FINISH;
      end
      S_SHIFT_DN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr - AW'(1);
        mem_req.wdata = rd_data;
        mem_req.raddr = ptr + AW'(1);
        if (ptr == last) begin
          count_next = count - CW'(1);
          state_next = S_FINISH;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      S_SCAN: begin
        mem_req.raddr = ptr + AW'(1);
        if (rd_data == op_value) begin
          hit_next   = 1'b1;
          state_next = S_FINISH;
        end else if (ptr == last) begin
          state_next = S_FINISH;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      S_RDWAIT: begin
        rdv_next   = rd_data;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_mode  <= op_mode_next;
    op_index <= op_index_next;
    op_value <= op_value_next;
    ptr      <= ptr_next;
    st       <= st_next;
    rdv      <= rdv_next;
    hit      <= hit_next;
    if (rsp_load) begin
      rsp.status     <= st;
      rsp.read_value <= rdv;
      rsp.found      <= hit;
      rsp.count      <= count_x[ilt_pkg::CountW-1:0];
    end
  end

  assign rsp.valid = rsp_valid;

endmodule
`default_nettype wire

// ----- rtl/core/indexed_list_table.sv -----
// Indexed list table: an ordered list of up to DEPTH signed 32-bit words with
// append, insert, delete, search and read commands, one result per request.
// Depends on ilt_pkg, ilt_ifs, ilt_mem and ilt_seq.
//
// One request is worked at a time; cmd.ready is high only while the block is
// idle. Every step goes through the entry memory (one write port, one read port
// with registered data), one address per cycle, so latency follows the entries
// walked. Append and out-of-range requests go from decode straight to the final
// state, read passes a read-wait state, insert shifts entries up from the last
// to the index and then places the word, delete shifts the entries after the
// index down, and search stops at the first match. A finished result waits in
// the output register while the next request is accepted; a result still held
// there stalls the next one in its final state until it drains. The entry
// memory needs no clearing after reset.
`default_nettype none
module indexed_list_table #(
  parameter int DEPTH = ilt_pkg::DefDepth
) (
  input  wire        clk,
  input  wire        rst,
  ilt_cmd_if.sink    cmd,
  ilt_rsp_if.source  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [ilt_pkg::WordW-1:0] wdata;
    logic [AW-1:0]             raddr;
  } mem_req_t;

  mem_req_t                  mem_req;
  logic [ilt_pkg::WordW-1:0] rd_data;

  ilt_mem #(
    .Depth (DEPTH),
    .req_t (mem_req_t)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  ilt_seq #(
    .Depth (DEPTH),
    .req_t (mem_req_t)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

// ----- tb/tb_indexed_list_table.sv -----
// Self-checking bench for indexed_list_table: a directed table, a fill to full depth,
// then a random grow/shrink walk, each result checked against pinned or model values.
// Depends on ilt_pkg, ilt_ifs and the indexed_list_table RTL.
module tb_indexed_list_table;

  localparam int DEPTH       = ilt_pkg::DefDepth;
  localparam int IndexTop    = DEPTH;
  localparam int CycleLimit  = 4_000_000;
  localparam int TailCycles  = 300;
  localparam int RandomItems = 1050;
  localparam int PhaseLen    = 150;

  localparam logic [ilt_pkg::ModeW-1:0] ModeSpare    = 3'd5;
  localparam logic [ilt_pkg::ModeW-1:0] ModeSpareTop = 3'd7;

  localparam logic signed [ilt_pkg::WordW-1:0] WordMin = 32'sh8000_0000;
  localparam logic signed [ilt_pkg::WordW-1:0] WordMax = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic        [ilt_pkg::ModeW-1:0]  mode;
    logic        [ilt_pkg::IndexW-1:0] index;
    logic signed [ilt_pkg::WordW-1:0]  value;
  } list_cmd_t;

  typedef struct packed {
    logic        [ilt_pkg::StatusW-1:0] status;
    logic signed [ilt_pkg::WordW-1:0]   read_value;
    logic                               found;
    logic        [ilt_pkg::CountW-1:0]  count;
  } list_rsp_t;

  typedef struct {
    list_cmd_t req;
    bit        pinned;
    list_rsp_t want;
  } table_row_t;

  logic clk;
  logic rst;

  ilt_cmd_if cmd_ch ();
  ilt_rsp_if rsp_ch ();

  indexed_list_table #(.DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  logic signed [ilt_pkg::WordW-1:0] shadow_words [DEPTH];
  int unsigned             shadow_len = 0;
  list_rsp_t               owed_q [$];
  table_row_t              rows_q [$];
  bit                      pin_on;
  list_rsp_t               pin_rsp;
  int                      send_idle_pct  = 0;
  int                      recv_stall_pct = 0;
  int                      err_count      = 0;
  int unsigned             cycle_count    = 0;
  bit                      growing        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic list_rsp_t apply_to_list(input list_cmd_t c);
    list_rsp_t r;
    int        i;
    r = '0;
    case (c.mode)
      ilt_pkg::ModeAppend: begin
        if (shadow_len >= DEPTH) begin
          r.status = ilt_pkg::StFull;
        end else begin
          shadow_words[shadow_len] = c.value;
          shadow_len++;
        end
      end
      ilt_pkg::ModeInsert: begin
        if (c.index > shadow_len) begin
          r.status = ilt_pkg::StRange;
        end else if (shadow_len >= DEPTH) begin
          r.status = ilt_pkg::StFull;
        end else begin
          for (i = shadow_len; i > c.index; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[c.index] = c.value;
          shadow_len++;
        end
      end
      ilt_pkg::ModeDelete: begin
        if (c.index >= shadow_len) begin
          r.status = ilt_pkg::StRange;
        end else begin
          for (i = c.index; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      ilt_pkg::ModeSearch: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == c.value) r.found = 1'b1;
        end
      end
      ilt_pkg::ModeRead: begin
        if (c.index >= shadow_len) begin
          r.status     = ilt_pkg::StRange;
          r.read_value = ilt_pkg::ReadMiss;
        end else begin
          r.read_value = shadow_words[c.index];
        end
      end
      default: ;
    endcase
    r.count = shadow_len[ilt_pkg::CountW-1:0];
    return r;
  endfunction

  always @(negedge clk) rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    list_cmd_t req;
    list_rsp_t got;
    list_rsp_t want;
    list_rsp_t calc;
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_indexed_list_table: errors");
      $finish;
    end else if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status     = rsp_ch.status;
        got.read_value = rsp_ch.read_value;
        got.found      = rsp_ch.found;
        got.count      = rsp_ch.count;
        if (owed_q.size() == 0) begin
          err_count++;
          $display("%0t: result with no request waiting: status %0d read %0d found %0d count %0d",
                   $time, got.status, got.read_value, got.found, got.count);
        end else begin
          want = owed_q.pop_front();
          if (got.status !== want.status) begin
            err_count++;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          end
          if (got.read_value !== want.read_value) begin
            err_count++;
            $display("%0t: read_value expected %0d got %0d", $time, want.read_value,
                     got.read_value);
          end
          if (got.found !== want.found) begin
            err_count++;
            $display("%0t: found expected %0d got %0d", $time, want.found, got.found);
          end
          if (got.count !== want.count) begin
            err_count++;
            $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        req.mode  = cmd_ch.mode;
        req.index = cmd_ch.index;
        req.value = cmd_ch.value;
        calc = apply_to_list(req);
        owed_q.push_back(pin_on ? pin_rsp : calc);
      end
    end
  end

  task automatic push_request(input list_cmd_t c, input bit pinned, input list_rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode  <= c.mode;
    cmd_ch.index <= c.index;
    cmd_ch.value <= c.value;
    pin_on       <= pinned;
    pin_rsp      <= want;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    cmd_ch.valid <= 1'b0;
    while (owed_q.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(input logic [ilt_pkg::ModeW-1:0] m, input int idx,
                         input logic signed [ilt_pkg::WordW-1:0] v);
    table_row_t row;
    row.req.mode  = m;
    row.req.index = ilt_pkg::IndexW'(idx);
    row.req.value = v;
    row.pinned    = 1'b0;
    row.want      = '0;
    rows_q.push_back(row);
  endtask

  task automatic add_pinned(input logic [ilt_pkg::ModeW-1:0] m, input int idx,
                            input logic signed [ilt_pkg::WordW-1:0] v,
                            input logic [ilt_pkg::StatusW-1:0] st,
                            input logic signed [ilt_pkg::WordW-1:0] rd, input logic fnd,
                            input int cnt);
    table_row_t row;
    row.req.mode        = m;
    row.req.index       = ilt_pkg::IndexW'(idx);
    row.req.value       = v;
    row.pinned          = 1'b1;
    row.want.status     = st;
    row.want.read_value = rd;
    row.want.found      = fnd;
    row.want.count      = ilt_pkg::CountW'(cnt);
    rows_q.push_back(row);
  endtask

  task automatic play_table();
    foreach (rows_q[i]) push_request(rows_q[i].req, rows_q[i].pinned, rows_q[i].want);
    rows_q.delete();
  endtask

  function automatic logic signed [ilt_pkg::WordW-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 25) return ilt_pkg::WordW'($urandom_range(4)) - 32'sd2;
    if (r < 35) begin
      case ($urandom_range(3))
        0:       return WordMin;
        1:       return WordMax;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 55 && shadow_len > 0) return shadow_words[$urandom_range(shadow_len - 1)];
    return $urandom;
  endfunction

  task automatic next_random();
    list_cmd_t   c;
    int          r;
    int unsigned n;
    n = shadow_len;
    if ($urandom_range(199) == 0 || (growing && n == DEPTH && $urandom_range(9) < 3) ||
        (!growing && n == 0 && $urandom_range(9) < 3)) growing = !growing;
    r = $urandom_range(99);
    c.index = ilt_pkg::IndexW'($urandom_range(IndexTop));
    c.value = pick_word();
    if (r < 2) c.mode = ModeSpare + ilt_pkg::ModeW'($urandom_range(2));
    else if (r < (growing ? 37 : 10)) c.mode = ilt_pkg::ModeAppend;
    else if (r < (growing ? 62 : 18)) c.mode = ilt_pkg::ModeInsert;
    else if (r < (growing ? 72 : 80)) c.mode = ilt_pkg::ModeDelete;
    else if (r < (growing ? 86 : 90)) c.mode = ilt_pkg::ModeSearch;
    else c.mode = ilt_pkg::ModeRead;
    case (c.mode) inside
      ilt_pkg::ModeInsert: begin
        if ($urandom_range(99) < 85) c.index = ilt_pkg::IndexW'($urandom_range(n));
      end
      ilt_pkg::ModeDelete, ilt_pkg::ModeRead: begin
        if (n > 0 && $urandom_range(99) < 85) c.index = ilt_pkg::IndexW'($urandom_range(n - 1));
        else c.index = ilt_pkg::IndexW'($urandom_range(IndexTop, n));
      end
      ilt_pkg::ModeSearch: begin
        if (n > 0 && $urandom_range(1) == 1) c.value = shadow_words[$urandom_range(n - 1)];
      end
      default: ;
    endcase
    push_request(c, 1'b0, '0);
  endtask

  initial begin
    list_cmd_t c;
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.mode    = ilt_pkg::ModeAppend;
    cmd_ch.index   = '0;
    cmd_ch.value   = '0;
    pin_on         = 1'b0;
    pin_rsp        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_pinned(ilt_pkg::ModeRead,   0,        0,       ilt_pkg::StRange, ilt_pkg::ReadMiss,
               1'b0, 0);
    add_pinned(ilt_pkg::ModeDelete, 0,        0,       ilt_pkg::StRange, 0,       1'b0, 0);
    add_pinned(ilt_pkg::ModeSearch, 0,        0,       ilt_pkg::StOk,    0,       1'b0, 0);
    add_pinned(ilt_pkg::ModeInsert, 1,        5,       ilt_pkg::StRange, 0,       1'b0, 0);
    add_pinned(ModeSpareTop,        IndexTop, -1,      ilt_pkg::StOk,    0,       1'b0, 0);
    add_pinned(ilt_pkg::ModeInsert, 0,        WordMin, ilt_pkg::StOk,    0,       1'b0, 1);
    add_pinned(ilt_pkg::ModeAppend, 0,        WordMax, ilt_pkg::StOk,    0,       1'b0, 2);
    add_row(ilt_pkg::ModeAppend, 0, -1);
    add_row(ilt_pkg::ModeAppend, 0, 0);
    add_row(ilt_pkg::ModeInsert, 4, 1);
    add_row(ilt_pkg::ModeInsert, 2, 32'sh5555_5555);
    add_pinned(ilt_pkg::ModeRead,   0,        0,       ilt_pkg::StOk,    WordMin, 1'b0, 6);
    add_pinned(ilt_pkg::ModeRead,   IndexTop, 0,       ilt_pkg::StRange, ilt_pkg::ReadMiss,
               1'b0, 6);
    add_pinned(ilt_pkg::ModeDelete, IndexTop, 0,       ilt_pkg::StRange, 0,       1'b0, 6);
    add_pinned(ilt_pkg::ModeInsert, IndexTop, 3,       ilt_pkg::StRange, 0,       1'b0, 6);
    add_row(ilt_pkg::ModeSearch, 0, WordMax);
    add_row(ilt_pkg::ModeSearch, 0, 32'sh1234_5678);
    add_row(ilt_pkg::ModeDelete, 0, 0);
    add_row(ilt_pkg::ModeDelete, 4, 0);
    play_table();
    wait_quiet();

    send_idle_pct = 62;
    while (shadow_len < DEPTH) begin
      c.mode  = ilt_pkg::ModeAppend;
      c.index = ilt_pkg::IndexW'($urandom_range(IndexTop));
      c.value = pick_word();
      push_request(c, 1'b0, '0);
    end

    add_pinned(ilt_pkg::ModeAppend, 0,        7, ilt_pkg::StFull, 0, 1'b0, DEPTH);
    add_pinned(ilt_pkg::ModeInsert, IndexTop, 8, ilt_pkg::StFull, 0, 1'b0, DEPTH);
    add_pinned(ilt_pkg::ModeInsert, 0,        9, ilt_pkg::StFull, 0, 1'b0, DEPTH);
    add_row(ilt_pkg::ModeRead,   DEPTH - 1, 0);
    add_row(ilt_pkg::ModeDelete, 0,         0);
    add_row(ilt_pkg::ModeInsert, DEPTH - 1, -2);
    play_table();
    wait_quiet();

    growing = 1'b0;
    for (int k = 0; k < RandomItems; k++) begin
      if (k % PhaseLen == 0) begin
        wait_quiet();
        case ((k / PhaseLen) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
          default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
      end
      next_random();
    end

    wait_quiet();
    repeat (TailCycles) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_indexed_list_table: clean");
    end else begin
      $display("tb_indexed_list_table: errors");
    end
    $finish;
  end

endmodule
